[sv/zlhw_pkg.sv]
package zlhw_pkg;

    // Result kinds, as carried on the master tuser
    typedef enum logic [1:0] {
        KIND_ENTRY   = 2'd0,
        KIND_NAME    = 2'd1,
        KIND_BAD_SIG = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    // Local file header signature, 'P' 'K' 3 4
    localparam logic [7:0] SIG_BYTE [4] = '{8'h50, 8'h4B, 8'h03, 8'h04};

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 176;

    // Everything one input word can produce: an optional first result
    // (entry, filename byte or bad signature) and an optional end result.
    // The end result shares the held fields of the first one.
    typedef struct packed {
        logic        has_first;
        kind_t       first_kind;
        logic [7:0]  name_char;
        logic        has_end;
        logic        truncated;
        logic [31:0] entry_offset;
        logic [15:0] name_length;
        logic [15:0] extra_length;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [31:0] entry_count;
    } rec_t;

    // One result word on the master side
    typedef struct packed {
        kind_t       kind;
        logic        last;
        logic [31:0] entry_offset;
        logic [15:0] name_length;
        logic [15:0] extra_length;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [7:0]  name_char;
        logic [31:0] entry_count;
        logic        truncated;
    } res_t;

endpackage

[sv/zlhw_parse.sv]
module zlhw_parse
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     data_byte,
    input  logic           end_of_stream,
    output logic           rec_valid,
    output zlhw_pkg::rec_t rec
);
    import zlhw_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_SKIP,
        PH_DEAD
    } phase_t;

    localparam logic [4:0] OFS_SIG_LAST = 5'd3;
    localparam logic [4:0] OFS_PACKED   = 5'd18;
    localparam logic [4:0] OFS_UNPACKED = 5'd22;
    localparam logic [4:0] OFS_NAME     = 5'd26;
    localparam logic [4:0] OFS_EXTRA    = 5'd28;
    localparam logic [4:0] OFS_HDR_LAST = 5'd29;

    phase_t      phase_reg,     phase_next;
    logic [4:0]  hdr_idx_reg,   hdr_idx_next;
    logic        sig_good_reg,  sig_good_next;
    logic [15:0] name_len_reg,  name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [31:0] packed_reg,    packed_next;
    logic [31:0] unpacked_reg,  unpacked_next;
    logic [32:0] skip_reg,      skip_next;
    logic [15:0] name_left_reg, name_left_next;
    logic [31:0] pos_reg,       pos_next;
    logic [31:0] start_reg,     start_next;
    logic [31:0] count_reg,     count_next;

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        sig_good_next  = sig_good_reg;
        name_len_next  = name_len_reg;
        extra_len_next = extra_len_reg;
        packed_next    = packed_reg;
        unpacked_next  = unpacked_reg;
        skip_next      = skip_reg;
        name_left_next = name_left_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        pos_next       = pos_reg + 32'd1;

        rec            = '0;
        rec.first_kind = KIND_ENTRY;

        unique case (phase_reg)
            PH_HEADER:
            begin
                // clear the held fields at the first header byte
                if (hdr_idx_reg == '0)
                begin
                    start_next     = pos_reg;
                    sig_good_next  = 1'b1;
                    name_len_next  = '0;
                    extra_len_next = '0;
                    packed_next    = '0;
                    unpacked_next  = '0;
                end
                if (hdr_idx_reg <= OFS_SIG_LAST)
                begin
                    if (data_byte != SIG_BYTE[hdr_idx_reg[1:0]])
                        sig_good_next = 1'b0;
                end
                else if (hdr_idx_reg >= OFS_PACKED && hdr_idx_reg < OFS_UNPACKED)
                    packed_next[{hdr_idx_reg[1:0] + 2'd2, 3'b000} +: 8] = data_byte;
                else if (hdr_idx_reg >= OFS_UNPACKED && hdr_idx_reg < OFS_NAME)
                    unpacked_next[{hdr_idx_reg[1:0] + 2'd2, 3'b000} +: 8] = data_byte;
                else if (hdr_idx_reg >= OFS_NAME && hdr_idx_reg < OFS_EXTRA)
                    name_len_next[{hdr_idx_reg[0], 3'b000} +: 8] = data_byte;
                else if (hdr_idx_reg >= OFS_EXTRA)
                    extra_len_next[{hdr_idx_reg[0], 3'b000} +: 8] = data_byte;

                if (hdr_idx_reg == OFS_SIG_LAST && !sig_good_next)
                begin
                    rec.has_first  = 1'b1;
                    rec.first_kind = KIND_BAD_SIG;
                    phase_next     = PH_DEAD;
                    hdr_idx_next   = '0;
                end
                else if (hdr_idx_reg >= OFS_HDR_LAST)
                begin
                    count_next     = count_reg + 32'd1;
                    rec.has_first  = 1'b1;
                    rec.first_kind = KIND_ENTRY;
                    hdr_idx_next   = '0;
                    name_left_next = name_len_next;
                    skip_next      = {17'd0, extra_len_next} + {1'b0, packed_next};
                    if (name_len_next != '0)
                        phase_next = PH_NAME;
                    else if (skip_next != '0)
                        phase_next = PH_SKIP;
                    else
                        phase_next = PH_HEADER;
                end
                else
                    hdr_idx_next = hdr_idx_reg + 5'd1;
            end
            PH_NAME:
            begin
                rec.has_first  = 1'b1;
                rec.first_kind = KIND_NAME;
                rec.name_char  = data_byte;
                name_left_next = name_left_reg - 16'd1;
                if (name_left_next == '0)
                    phase_next = (skip_reg != '0) ? PH_SKIP : PH_HEADER;
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 33'd1;
                if (skip_next == '0)
                    phase_next = PH_HEADER;
            end
            PH_DEAD:
            begin
            end
            default:
            begin
            end
        endcase

        rec.entry_offset  = start_next;
        rec.name_length   = name_len_next;
        rec.extra_length  = extra_len_next;
        rec.packed_size   = packed_next;
        rec.unpacked_size = unpacked_next;
        rec.entry_count   = count_next;

        if (end_of_stream)
        begin
            rec.has_end   = 1'b1;
            rec.truncated = (phase_next == PH_NAME) || (phase_next == PH_SKIP) ||
                            (phase_next == PH_HEADER && hdr_idx_next != '0);
            // start over for a new stream
            phase_next     = PH_HEADER;
            hdr_idx_next   = '0;
            sig_good_next  = 1'b1;
            name_len_next  = '0;
            extra_len_next = '0;
            packed_next    = '0;
            unpacked_next  = '0;
            skip_next      = '0;
            name_left_next = '0;
            pos_next       = '0;
            start_next     = '0;
            count_next     = '0;
        end

        rec_valid = step && (rec.has_first || rec.has_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= '0;
            sig_good_reg  <= 1'b1;
            name_len_reg  <= '0;
            extra_len_reg <= '0;
            packed_reg    <= '0;
            unpacked_reg  <= '0;
            skip_reg      <= '0;
            name_left_reg <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            sig_good_reg  <= sig_good_next;
            name_len_reg  <= name_len_next;
            extra_len_reg <= extra_len_next;
            packed_reg    <= packed_next;
            unpacked_reg  <= unpacked_next;
            skip_reg      <= skip_next;
            name_left_reg <= name_left_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
        end
    end

endmodule

[sv/zlhw_outq.sv]
module zlhw_outq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zlhw_pkg::rec_t push_rec,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output zlhw_pkg::res_t out_res
);
    import zlhw_pkg::*;

    rec_t head_reg, head_next;
    rec_t tail_reg, tail_next;
    logic head_vld_reg, head_vld_next;
    logic tail_vld_reg, tail_vld_next;
    logic sub_reg, sub_next;       // first result of the head already sent
    logic show_first;
    logic pop;

    assign in_ready  = !tail_vld_reg;
    assign out_valid = head_vld_reg;

    always_comb
    begin
        show_first            = head_reg.has_first && !sub_reg;
        out_res.entry_offset  = head_reg.entry_offset;
        out_res.name_length   = head_reg.name_length;
        out_res.extra_length  = head_reg.extra_length;
        out_res.packed_size   = head_reg.packed_size;
        out_res.unpacked_size = head_reg.unpacked_size;
        out_res.entry_count   = head_reg.entry_count;
        if (show_first)
        begin
            out_res.kind      = head_reg.first_kind;
            out_res.name_char = head_reg.name_char;
            out_res.truncated = 1'b0;
            out_res.last      = !head_reg.has_end;
        end
        else
        begin
            out_res.kind      = KIND_END;
            out_res.name_char = '0;
            out_res.truncated = head_reg.truncated;
            out_res.last      = 1'b1;
        end
        pop = head_vld_reg && out_ready && out_res.last;
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        sub_next      = sub_reg;

        if (pop)
        begin
            // advance the tail into the head
            head_next     = tail_reg;
            head_vld_next = tail_vld_reg;
            tail_vld_next = 1'b0;
            sub_next      = 1'b0;
        end
        else if (head_vld_reg && out_ready)
            sub_next = 1'b1;

        if (push)
        begin
            if (!head_vld_next)
            begin
                head_next     = push_rec;
                head_vld_next = 1'b1;
            end
            else
            begin
                tail_next     = push_rec;
                tail_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
            sub_reg      <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
            sub_reg      <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

[sv/zip_local_header_walker.sv]
// Channel   Dir  Word                                   Marks
// s_axis    in   tdata: data_byte                       tlast: end_of_stream
// m_axis    out  tdata: result fields, tuser: kind      tlast: final result of the word
//
// One archive byte is taken per cycle while the result queue can accept it. Header
// capture, signature check, name and skip counting are all computed combinationally
// from the byte and the walker state. Each byte yields zero, one or two results;
// a two-entry result queue parts the two sides, so a word is taken whenever its
// tail slot is free. A byte that yields two results holds the head until both go out.
// Reset clears the walker to the header phase and empties the queue.
// Master stalls back up through the queue into s_axis_tready; nothing is dropped.
module zip_local_header_walker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [zlhw_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [7:0] data_byte
    input  logic                                   s_axis_tlast,  // end_of_stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [31:0] entry_offset, [47:32] name_length, [63:48] extra_length,
    // [95:64] packed_size, [127:96] unpacked_size, [135:128] name_char,
    // [167:136] entry_count, [168] truncated, [175:169] zero
    output logic [zlhw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [1:0]                             m_axis_tuser,  // [1:0] kind
    output logic                                   m_axis_tlast   // last result of the byte
);
    import zlhw_pkg::*;

    logic step;
    logic rec_valid;
    rec_t rec;
    res_t res;

    // take a byte on every handshake
    assign step = s_axis_tvalid && s_axis_tready;

    zlhw_parse u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .rec_valid     (rec_valid),
        .rec           (rec)
    );

    // hold results until the master takes them
    zlhw_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_valid),
        .push_rec  (rec),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {7'd0,
                           res.truncated,
                           res.entry_count,
                           res.name_char,
                           res.unpacked_size,
                           res.packed_size,
                           res.extra_length,
                           res.name_length,
                           res.entry_offset};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
